>>> hdl/button_debounce_long_push_assert.svh
// Assertion macros used by the debouncer's output register module.
// Both macros sample on clk_i and hold off while rst_ni is low.
`ifndef BUTTON_DEBOUNCE_LONG_PUSH_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PUSH_ASSERT_SVH

`define BDL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define BDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bdl_pkg.sv
package bdl_pkg;

  localparam int BUTTON_COUNT = 4;
  localparam int PIN_W        = 4;
  localparam int IDX_W        = 3;
  localparam int CNT_W        = 8;
  localparam int OP_W         = 2;
  localparam int CODE_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
  localparam logic [OP_W-1:0] OP_LONG  = 2'd2;

  localparam logic [CODE_W-1:0] CODE_NONE     = 2'd0;
  localparam logic [CODE_W-1:0] CODE_RELEASED = 2'd1;
  localparam logic [CODE_W-1:0] CODE_PUSHED   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASED = 2'd2;

  localparam logic [CNT_W-1:0] RESET_DEBOUNCE = 8'd3;
  localparam logic [CNT_W-1:0] RESET_LONG     = 8'd100;
  localparam logic [PIN_W-1:0] RESET_RELEASED = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [PIN_W-1:0] pin_levels;
    logic [IDX_W-1:0] button_index;
  } bdl_item_t;

  typedef struct packed {
    logic tick;
    logic clr_change;
  } bdl_cell_ctrl_t;

  typedef struct packed {
    logic pushed;
    logic change;
    logic long_flag;
  } bdl_cell_stat_t;

endpackage

>>> hdl/bdl_if.sv
interface bdl_in_if import bdl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [PIN_W-1:0] pin_levels;
  logic [IDX_W-1:0] button_index;

  modport source (output valid, operation, pin_levels, button_index, input ready);
  modport sink   (input valid, operation, pin_levels, button_index, output ready);
endinterface

interface bdl_out_if import bdl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] change_code;
  logic              long_hit;

  modport source (output valid, change_code, long_hit, input ready);
  modport sink   (input valid, change_code, long_hit, output ready);
endinterface

interface bdl_cfg_if import bdl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/bdl_in_reg.sv
module bdl_in_reg import bdl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdl_in_if.sink    in_i,
  input  logic      take_i,
  output logic      valid_o,
  output bdl_item_t item_o
);

  logic      valid_q, valid_d;
  bdl_item_t item_q;

  assign in_i.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= '{operation: in_i.operation, pin_levels: in_i.pin_levels,
                  button_index: in_i.button_index};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hdl/bdl_button.sv
module bdl_button import bdl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bdl_cell_ctrl_t   ctrl_i,
  input  logic             pin_i,
  input  logic             rel_i,
  input  logic             rst_level_i,
  input  logic [CNT_W-1:0] deb_ticks_i,
  input  logic [CNT_W-1:0] long_ticks_i,
  output bdl_cell_stat_t   stat_o
);

  // flip_q holds the debounced level relative to its reset value
  logic             flip_q, flip_d;
  logic [CNT_W-1:0] deb_q, deb_d;
  logic [CNT_W-1:0] hold_q, hold_d;
  logic             chg_q, chg_d;
  logic             long_q, long_d;
  logic             level, level_n;
  logic [CNT_W-1:0] deb_inc, hold_inc;

  assign level   = flip_q ^ rst_level_i;
  assign deb_inc = deb_q + CNT_W'(1);

  always_comb begin
    flip_d   = flip_q;
    deb_d    = deb_q;
    hold_d   = hold_q;
    chg_d    = chg_q;
    long_d   = long_q;
    level_n  = level;
    hold_inc = '0;
    if (ctrl_i.tick) begin
      if (pin_i != level) begin
        if (deb_inc >= deb_ticks_i) begin
          level_n = pin_i;
          flip_d  = pin_i ^ rst_level_i;
          chg_d   = 1'b1;
          deb_d   = '0;
        end else begin
          deb_d = deb_inc;
        end
      end else begin
        deb_d = '0;
      end
      hold_inc = (level_n != rel_i) ? hold_q + CNT_W'(1) : '0;
      if (hold_inc >= long_ticks_i) begin
        long_d = 1'b1;
        hold_d = '0;
      end else begin
        long_d = 1'b0;
        hold_d = hold_inc;
      end
    end else if (ctrl_i.clr_change) begin
      chg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q <= 1'b0;
      deb_q  <= '0;
      hold_q <= '0;
      chg_q  <= 1'b0;
      long_q <= 1'b0;
    end else begin
      flip_q <= flip_d;
      deb_q  <= deb_d;
      hold_q <= hold_d;
      chg_q  <= chg_d;
      long_q <= long_d;
    end
  end

  assign stat_o = '{pushed: level != rel_i, change: chg_q, long_flag: long_q};

endmodule

>>> hdl/bdl_out_reg.sv
module bdl_out_reg import bdl_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  bdl_item_t      item_i,
  input  bdl_cell_stat_t stat_i [BUTTON_COUNT],
  output logic           take_o,
  output bdl_cell_ctrl_t ctrl_o [BUTTON_COUNT],
  bdl_out_if.source      out_o
);

`include "button_debounce_long_push_assert.svh"

  logic              res_valid_q, res_valid_d;
  logic [CODE_W-1:0] res_code_q, res_code_d;
  logic              res_long_q, res_long_d;
  logic              is_query;
  logic [BUTTON_COUNT-1:0] clr_vec;

  assign is_query = (item_i.operation == OP_CHECK) || (item_i.operation == OP_LONG);
  assign take_o   = valid_i && (!is_query || !res_valid_q || out_o.ready);

  always_comb begin
    res_code_d = CODE_NONE;
    res_long_d = 1'b0;
    clr_vec    = '0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      ctrl_o[i].tick       = take_o && (item_i.operation == OP_TICK);
      ctrl_o[i].clr_change = 1'b0;
      if (item_i.button_index == IDX_W'(i)) begin
        if (item_i.operation == OP_CHECK && stat_i[i].change) begin
          res_code_d           = stat_i[i].pushed ? CODE_PUSHED : CODE_RELEASED;
          ctrl_o[i].clr_change = take_o;
          clr_vec[i]           = take_o;
        end
        if (item_i.operation == OP_LONG) begin
          res_long_d = stat_i[i].long_flag;
        end
      end
      if (item_i.operation == OP_LONG && item_i.button_index == IDX_W'(BUTTON_COUNT)
          && stat_i[i].long_flag) begin
        res_long_d = 1'b1;
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (take_o && is_query) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && is_query) begin
      res_code_q <= res_code_d;
      res_long_q <= res_long_d;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.change_code = res_code_q;
  assign out_o.long_hit    = res_long_q;

  `BDL_ASSERT_NEXT(a_query_gives_result, take_o && is_query,
    res_valid_q, "accepted query left no result")
  `BDL_ASSERT_SAME(a_clear_only_on_check, clr_vec != '0,
    take_o && item_i.operation == OP_CHECK && $onehot(clr_vec),
    "change flag cleared outside a single check")
  `BDL_ASSERT_NEXT(a_long_result_no_code, take_o && item_i.operation == OP_LONG,
    res_code_q == CODE_NONE, "long-push query returned a change code")
  `BDL_ASSERT_NEXT(a_bad_index_quiet,
    take_o && is_query && item_i.button_index > IDX_W'(BUTTON_COUNT),
    res_code_q == CODE_NONE && !res_long_q, "out-of-range index gave a hit")

endmodule

>>> hdl/button_debounce_long_push.sv
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   operation, pin_levels, button_index
// out_o     out  valid/ready   change_code, long_hit
// cfg_i     in   valid/ready   index, data (ready always high)
//
// One item per cycle unless a query stalls: input register, then per-button update and result register.
// A query result is loaded into the result register when its item is taken from the input register.
// in_i.ready depends combinationally on out_o.ready through the result register.
// Ticks give no result and pass a stalled output; a query waits for a free slot.
// Reset restores config registers, valid flags and button state at once; no clearing pass.
module button_debounce_long_push import bdl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdl_in_if.sink    in_i,
  bdl_out_if.source out_o,
  bdl_cfg_if.sink   cfg_i
);

  logic [CNT_W-1:0] deb_ticks_q;
  logic [CNT_W-1:0] long_ticks_q;
  logic [PIN_W-1:0] released_q;

  logic           item_valid;
  bdl_item_t      item;
  logic           take;
  bdl_cell_ctrl_t ctrl [BUTTON_COUNT];
  bdl_cell_stat_t stat [BUTTON_COUNT];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q  <= RESET_DEBOUNCE;
      long_ticks_q <= RESET_LONG;
      released_q   <= RESET_RELEASED;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DEBOUNCE: deb_ticks_q  <= cfg_i.data;
        REG_LONG:     long_ticks_q <= cfg_i.data;
        REG_RELEASED: released_q   <= cfg_i.data[PIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bdl_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_button
    logic pin, rel, rst_level;
    if (g < PIN_W) begin : g_pin
      assign pin       = item.pin_levels[g];
      assign rel       = released_q[g];
      assign rst_level = RESET_RELEASED[g];
    end else begin : g_nopin
      assign pin       = 1'b0;
      assign rel       = 1'b0;
      assign rst_level = 1'b0;
    end

    bdl_button u_button (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[g]),
      .pin_i        (pin),
      .rel_i        (rel),
      .rst_level_i  (rst_level),
      .deb_ticks_i  (deb_ticks_q),
      .long_ticks_i (long_ticks_q),
      .stat_o       (stat[g])
    );
  end

  bdl_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid),
    .item_i  (item),
    .stat_i  (stat),
    .take_o  (take),
    .ctrl_o  (ctrl),
    .out_o   (out_o)
  );

endmodule
